/* design/glyph_point_decoder_assert.svh */
// ----------------------------------------------------------------------------
// glyph point decoder assertion macros
// Shared forms for the concurrent checks on the decoder ports.
// ----------------------------------------------------------------------------
`ifndef GLYPH_POINT_DECODER_ASSERT_SVH
`define GLYPH_POINT_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GPD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/gpd_pkg.sv */
// ----------------------------------------------------------------------------
// gpd_pkg
// Types, codes, widths and the axis delta decode shared by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gpd_pkg;

   // flag store capacity and derived widths
   localparam int MAX_POINTS = 1024;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int FLAG_W     = 4;

   // field widths
   localparam int ACT_W  = 2;
   localparam int PC_W   = 11;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 32;
   localparam int USED_W = 2;
   localparam int STS_W  = 2;
   localparam int RPT_W  = 8;

   // request tdata layout, lowest bit first
   localparam int PC_LSB       = 0;
   localparam int DB_LSB       = PC_LSB + PC_W;
   localparam int XB1_LSB      = DB_LSB + BYTE_W;
   localparam int XB2_LSB      = XB1_LSB + BYTE_W;
   localparam int YB1_LSB      = XB2_LSB + BYTE_W;
   localparam int YB2_LSB      = YB1_LSB + BYTE_W;
   localparam int REQ_USED_W   = YB2_LSB + BYTE_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata layout, lowest bit first
   localparam int XPOS_LSB     = 0;
   localparam int YPOS_LSB     = XPOS_LSB + POS_W;
   localparam int XUSED_LSB    = YPOS_LSB + POS_W;
   localparam int YUSED_LSB    = XUSED_LSB + USED_W;
   localparam int RSP_USED_W   = YUSED_LSB + USED_W;
   localparam int RSP_DATA_W   = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_USED_W;

   // stored flag bits
   localparam int FL_XSHORT = 0;
   localparam int FL_YSHORT = 1;
   localparam int FL_XSAME  = 2;
   localparam int FL_YSAME  = 3;

   // flag byte bit that starts a repeat run
   localparam int FB_REPEAT = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_START = 2'd0,
      ACT_FLAG  = 2'd1,
      ACT_STEP  = 2'd2
   } gpd_action_type;

   typedef enum logic [STS_W-1:0] {
      STS_POINT_OK    = 2'd0,
      STS_FLAGS_SHORT = 2'd1,
      STS_NO_POINTS   = 2'd2
   } gpd_status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_REPEAT,
      SEQ_DECODE
   } gpd_state_type;

   typedef struct packed {
      logic [POS_W-1:0]  delta;
      logic [USED_W-1:0] used;
   } gpd_delta_type;

   // control from the sequencer to the point accumulator
   typedef struct packed {
      logic              clear;
      logic              load;
      gpd_status_type    status;
      logic              last;
      logic [BYTE_W-1:0] x_first;
      logic [BYTE_W-1:0] x_second;
      logic [BYTE_W-1:0] y_first;
      logic [BYTE_W-1:0] y_second;
   } gpd_step_type;

   // one axis: short delta with sign from the same bit, zero, or int16
   function automatic gpd_delta_type axis_delta(
      input logic              is_short,
      input logic              is_same,
      input logic [BYTE_W-1:0] b1,
      input logic [BYTE_W-1:0] b2
   );
      gpd_delta_type r;
      if (is_short) begin
         r.used  = USED_W'(1);
         r.delta = is_same ? POS_W'(b1) : (POS_W'(0) - POS_W'(b1));
      end else if (is_same) begin
         r.used  = USED_W'(0);
         r.delta = '0;
      end else begin
         r.used  = USED_W'(2);
         r.delta = POS_W'($signed({b1, b2}));
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/gpd_flag_ram.sv */
// ----------------------------------------------------------------------------
// gpd_flag_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_flag_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/gpd_point_acc.sv */
// ----------------------------------------------------------------------------
// gpd_point_acc
// Decodes x and y deltas, keeps the running sums and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_point_acc (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gpd_pkg::gpd_step_type           step,
   input  wire logic [gpd_pkg::FLAG_W-1:0]      flag,
   output      logic                            out_free,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [gpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output      logic                            rsp_tlast,
   output      logic [gpd_pkg::STS_W-1:0]       rsp_tuser
);

   import gpd_pkg::*;

   gpd_delta_type              x_delta;
   gpd_delta_type              y_delta;
   logic [POS_W-1:0]           x_sum_ff;
   logic [POS_W-1:0]           y_sum_ff;
   logic [POS_W-1:0]           x_sum_in;
   logic [POS_W-1:0]           y_sum_in;
   logic                       point_ok;
   logic                       rsp_valid_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_ff;
   logic                       rsp_last_ff;
   logic [STS_W-1:0]           rsp_user_ff;

   // per-axis delta decode from the stored flag
   assign x_delta  = axis_delta(flag[FL_XSHORT], flag[FL_XSAME], step.x_first, step.x_second);
   assign y_delta  = axis_delta(flag[FL_YSHORT], flag[FL_YSAME], step.y_first, step.y_second);
   assign x_sum_in = x_sum_ff + x_delta.delta;
   assign y_sum_in = y_sum_ff + y_delta.delta;
   assign point_ok = (step.status == STS_POINT_OK);

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // running sums, cleared by a start item
   always_ff @(posedge clock) begin
      if (reset) begin
         x_sum_ff <= '0;
         y_sum_ff <= '0;
      end else if (step.clear) begin
         x_sum_ff <= '0;
         y_sum_ff <= '0;
      end else if (step.load && point_ok) begin
         x_sum_ff <= x_sum_in;
         y_sum_ff <= y_sum_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, zero fields unless the point decoded
   always_ff @(posedge clock) begin
      if (step.load) begin
         if (point_ok) begin
            rsp_data_ff <= {{RSP_PAD_W{1'b0}}, y_delta.used, x_delta.used, y_sum_in, x_sum_in};
         end else begin
            rsp_data_ff <= '0;
         end
         rsp_last_ff <= point_ok && step.last;
         rsp_user_ff <= step.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

/* design/glyph_point_decoder.sv */
// ----------------------------------------------------------------------------
// glyph_point_decoder
// Simple glyph point decoder: flag run expansion into a flag store and
// delta decoding of x and y coordinates into running positions.
// ----------------------------------------------------------------------------
//
//   channel  direction  tdata                          tuser     tlast
//   req_     in         point_count, data_byte, x/y    action    -
//                       stream bytes (two per axis)
//   rsp_     out        x_pos, y_pos, x_used, y_used   status    last_point
//
// A start item and a plain flag byte leave the sequencer idle.
// A repeat count byte of n writes the run of n held flags into the flag store
// one entry per cycle; a run cut short by the point count ends once the store
// is full up to the point count.
// A step item passes through the flag store's registered read, then the delta
// decode and sum update into the output register.
// Reset (synchronous) clears the counters, sums and the result valid flag; the
// flag store has no clearing pass. A stalled result holds the step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_point_decoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // point_count[10:0], data_byte, x_byte_first, x_byte_second,
   // y_byte_first, y_byte_second, zero fill
   input  wire logic [gpd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action
   input  wire logic [gpd_pkg::ACT_W-1:0]       req_tuser,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // x_pos[31:0], y_pos[31:0], x_used[1:0], y_used[1:0], zero fill
   output      logic [gpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output      logic [gpd_pkg::STS_W-1:0]       rsp_tuser,
   output      logic                            rsp_tlast,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready
);

   import gpd_pkg::*;

   gpd_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [CNT_W-1:0]    filled_ff, filled_in;
   logic [CNT_W-1:0]    next_ff, next_in;
   logic                pending_ff, pending_in;
   logic [FLAG_W-1:0]   held_ff, held_in;
   logic [RPT_W-1:0]    rem_ff, rem_in;
   gpd_status_type      status_ff, status_in;
   logic                last_ff, last_in;
   logic [BYTE_W-1:0]   xb1_ff, xb2_ff, yb1_ff, yb2_ff;

   logic                accept;
   logic [PC_W-1:0]     point_count;
   logic [BYTE_W-1:0]   data_byte;
   logic [FLAG_W-1:0]   new_flag;
   logic                room;
   logic [CNT_W-1:0]    next_inc;
   logic                wr_en;
   logic [FLAG_W-1:0]   wr_data;
   logic                rd_en;
   logic [FLAG_W-1:0]   rd_flag;
   logic                out_free;
   gpd_step_type        step;

   // request fields
   assign point_count = req_tdata[PC_LSB +: PC_W];
   assign data_byte   = req_tdata[DB_LSB +: BYTE_W];
   assign new_flag    = {data_byte[5:4], data_byte[2:1]};

   assign req_tready = (state_ff == SEQ_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign room       = (filled_ff < total_ff);
   assign next_inc   = next_ff + CNT_W'(1);

   // sequencer: next state, counters and store accesses
   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      filled_in     = filled_ff;
      next_in       = next_ff;
      pending_in    = pending_ff;
      held_in       = held_ff;
      rem_in        = rem_ff;
      status_in     = status_ff;
      last_in       = last_ff;
      wr_en         = 1'b0;
      wr_data       = held_ff;
      rd_en         = 1'b0;
      step.clear    = 1'b0;
      step.load     = 1'b0;
      step.status   = status_ff;
      step.last     = last_ff;
      step.x_first  = xb1_ff;
      step.x_second = xb2_ff;
      step.y_first  = yb1_ff;
      step.y_second = yb2_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  ACT_START: begin
                     if (32'(point_count) > 32'(MAX_POINTS)) begin
                        total_in = CNT_W'(MAX_POINTS);
                     end else begin
                        total_in = CNT_W'(point_count);
                     end
                     filled_in  = '0;
                     pending_in = 1'b0;
                     held_in    = '0;
                     next_in    = '0;
                     step.clear = 1'b1;
                  end
                  ACT_FLAG: begin
                     if (pending_ff) begin
                        // repeat count byte
                        pending_in = 1'b0;
                        if (data_byte != '0) begin
                           rem_in   = data_byte;
                           state_in = SEQ_REPEAT;
                        end
                     end else begin
                        if (room) begin
                           wr_en     = 1'b1;
                           wr_data   = new_flag;
                           filled_in = filled_ff + CNT_W'(1);
                        end
                        if (data_byte[FB_REPEAT]) begin
                           held_in    = new_flag;
                           pending_in = 1'b1;
                        end
                     end
                  end
                  ACT_STEP: begin
                     rd_en = 1'b1;
                     if (next_ff >= total_ff) begin
                        status_in = STS_NO_POINTS;
                     end else if (next_ff >= filled_ff) begin
                        status_in = STS_FLAGS_SHORT;
                     end else begin
                        status_in = STS_POINT_OK;
                     end
                     last_in  = (next_inc == total_ff);
                     state_in = SEQ_DECODE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEQ_REPEAT: begin
            // one copy of the held flag per cycle
            if (room) begin
               wr_en     = 1'b1;
               filled_in = filled_ff + CNT_W'(1);
            end
            rem_in = rem_ff - RPT_W'(1);
            if (rem_ff == RPT_W'(1) || !room) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_DECODE: begin
            if (out_free) begin
               step.load = 1'b1;
               if (status_ff == STS_POINT_OK) begin
                  next_in = next_inc;
               end
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SEQ_IDLE;
         total_ff   <= '0;
         filled_ff  <= '0;
         next_ff    <= '0;
         pending_ff <= 1'b0;
         held_ff    <= '0;
         rem_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         filled_ff  <= filled_in;
         next_ff    <= next_in;
         pending_ff <= pending_in;
         held_ff    <= held_in;
         rem_ff     <= rem_in;
      end
   end

   // step payload captured at the transfer
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      last_ff   <= last_in;
      if (rd_en) begin
         xb1_ff <= req_tdata[XB1_LSB +: BYTE_W];
         xb2_ff <= req_tdata[XB2_LSB +: BYTE_W];
         yb1_ff <= req_tdata[YB1_LSB +: BYTE_W];
         yb2_ff <= req_tdata[YB2_LSB +: BYTE_W];
      end
   end

   // flag store
   gpd_flag_ram #(
      .DEPTH (MAX_POINTS),
      .WIDTH (FLAG_W)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (filled_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (next_ff[ADDR_W-1:0]),
      .rd_data (rd_flag)
   );

   // delta decode, sums and result register
   gpd_point_acc u_point_acc (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .flag       (rd_flag),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* design/gpd_checker.sv */
// ----------------------------------------------------------------------------
// gpd_checker
// Port-level checks on the glyph point decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_point_decoder_assert.svh"

module gpd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic [gpd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input wire logic [gpd_pkg::ACT_W-1:0]       req_tuser,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [gpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [gpd_pkg::STS_W-1:0]       rsp_tuser,
   input wire logic                            rsp_tlast,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready
);

   import gpd_pkg::*;

   logic start_xfer;
   logic point_ok;
   logic used_ok;

   assign start_xfer = req_tvalid && req_tready && (req_tuser == ACT_START);
   assign point_ok   = (rsp_tuser == STS_POINT_OK);
   assign used_ok    = (rsp_tdata[XUSED_LSB +: USED_W] != USED_W'(3)) &&
                       (rsp_tdata[YUSED_LSB +: USED_W] != USED_W'(3));

   // a failed step carries no position, byte counts or last marker
   `GPD_ASSERT_SAME(a_fail_zero, clock, reset, rsp_tvalid && !point_ok, rsp_tdata == '0 && !rsp_tlast, "failed step result carries data")
   // last point only on a decoded point, byte counts never three
   `GPD_ASSERT_SAME(a_last_used, clock, reset, rsp_tvalid, (point_ok || !rsp_tlast) && used_ok, "bad last marker or byte count")
   // a start transfer with no result waiting produces no result
   `GPD_ASSERT_NEXT(a_start_quiet, clock, reset, start_xfer && !rsp_tvalid, !rsp_tvalid, "result after start transfer")
   // reset empties the result register
   `GPD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")
   // a stalled result holds
   `GPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

endmodule

bind glyph_point_decoder gpd_checker u_gpd_checker (.*);

`default_nettype wire

/* verif/tb_glyph_point_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_point_decoder
// Self-checking bench for the glyph point decoder. Start, flag and step items
// go in on the request stream. A scoreboard keeps its own flag store, counters
// and running sums, and predicts each point result. Results are checked field
// by field, in order, while both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------

module tb_glyph_point_decoder;
   import gpd_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int unsigned      CYCLE_LIMIT = 5_000_000;
   localparam int               IDLE_PCT    = 7;
   localparam int               STALL_LEN   = 400;

   // one expected point result
   typedef struct packed {
      logic [POS_W-1:0]  x_pos;
      logic [POS_W-1:0]  y_pos;
      logic [USED_W-1:0] x_used;
      logic [USED_W-1:0] y_used;
      logic              last;
      gpd_status_type    status;
   } point_rec_type;

   // tracks glyph state and holds the points still to come out
   class point_tracker;
      logic [FLAG_W-1:0] flag_mem [MAX_POINTS];
      int unsigned       filled;
      int unsigned       total;
      int unsigned       next_pt;
      bit                run_pending;
      logic [FLAG_W-1:0] run_flag;
      logic [POS_W-1:0]  x_acc;
      logic [POS_W-1:0]  y_acc;
      point_rec_type     expected_points [$];
      int                errors;
      int                n_ok;
      int                n_short;
      int                n_done;

      function new();
         filled      = 0;
         total       = 0;
         next_pt     = 0;
         run_pending = 0;
         run_flag    = '0;
         x_acc       = '0;
         y_acc       = '0;
         errors      = 0;
         n_ok        = 0;
         n_short     = 0;
         n_done      = 0;
      endfunction

      // short delta signed by the same bit, zero, or big-endian int16
      function logic [POS_W-1:0] axis_delta_of(bit is_short, bit is_same,
                                               logic [7:0] b1, logic [7:0] b2,
                                               output logic [USED_W-1:0] used);
         if (is_short) begin
            used = 2'd1;
            return is_same ? {24'd0, b1} : (32'd0 - {24'd0, b1});
         end
         if (is_same) begin
            used = 2'd0;
            return '0;
         end
         used = 2'd2;
         return {{16{b1[7]}}, b1, b2};
      endfunction

      // entries past the point count are dropped
      function void store_flag(logic [FLAG_W-1:0] f);
         if (filled < total && filled < MAX_POINTS) begin
            flag_mem[filled] = f;
            filled++;
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      // update state for one accepted request
      function void note_item(logic [ACT_W-1:0] act, logic [PC_W-1:0] pc,
                              logic [7:0] db, logic [7:0] xb1, logic [7:0] xb2,
                              logic [7:0] yb1, logic [7:0] yb2);
         point_rec_type     r;
         logic [FLAG_W-1:0] f;
         logic [USED_W-1:0] xu;
         logic [USED_W-1:0] yu;
         case (act)
            ACT_START: begin
               total       = (pc > MAX_POINTS) ? MAX_POINTS : pc;
               filled      = 0;
               run_pending = 0;
               run_flag    = '0;
               next_pt     = 0;
               x_acc       = '0;
               y_acc       = '0;
            end
            ACT_FLAG: begin
               if (run_pending) begin
                  run_pending = 0;
                  for (int n = 0; n < db; n++) store_flag(run_flag);
               end else begin
                  f = {db[5:4], db[2:1]};
                  store_flag(f);
                  if (db[FB_REPEAT]) begin
                     run_flag    = f;
                     run_pending = 1;
                  end
               end
            end
            ACT_STEP: begin
               r = '0;
               if (next_pt >= total) begin
                  r.status = STS_NO_POINTS;
               end else if (next_pt >= filled) begin
                  r.status = STS_FLAGS_SHORT;
               end else begin
                  f = flag_mem[next_pt];
                  x_acc = x_acc + axis_delta_of(f[FL_XSHORT], f[FL_XSAME], xb1, xb2, xu);
                  y_acc = y_acc + axis_delta_of(f[FL_YSHORT], f[FL_YSAME], yb1, yb2, yu);
                  next_pt++;
                  r.status = STS_POINT_OK;
                  r.x_pos  = x_acc;
                  r.y_pos  = y_acc;
                  r.x_used = xu;
                  r.y_used = yu;
                  r.last   = (next_pt == total);
               end
               expected_points.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      // compare one result transfer with the oldest expectation
      function void check_point(logic [RSP_DATA_W-1:0] data, logic [STS_W-1:0] sts,
                                logic lst);
         point_rec_type want;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual status %0d x_pos %h",
                     $time, sts, data[XPOS_LSB +: POS_W]);
            errors++;
            return;
         end
         want = expected_points.pop_front();
         compare_field("x_pos", want.x_pos, data[XPOS_LSB +: POS_W]);
         compare_field("y_pos", want.y_pos, data[YPOS_LSB +: POS_W]);
         compare_field("x_used", want.x_used, data[XUSED_LSB +: USED_W]);
         compare_field("y_used", want.y_used, data[YUSED_LSB +: USED_W]);
         compare_field("last_point", want.last, lst);
         compare_field("status", want.status, sts);
         case (want.status)
            STS_POINT_OK:    n_ok++;
            STS_FLAGS_SHORT: n_short++;
            default:         n_done++;
         endcase
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [ACT_W-1:0]      req_tuser  = ACT_START;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   wire  [STS_W-1:0]      rsp_tuser;
   wire                   rsp_tlast;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   point_tracker tracker;
   int           items_sent   = 0;
   int           n_starts     = 0;
   int           n_flags      = 0;
   int           n_steps      = 0;
   int           results_seen = 0;
   bit           calm         = 0;
   int unsigned  cycles       = 0;

   glyph_point_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run timeout
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d points still expected", cycles,
               tracker.pending());
      $display("[glyph_point_decoder] ERROR");
      $finish;
   end

   // result side: check transfers, random stalls, one long hold-off
   initial begin
      int  hold_left;
      bit  held_once;
      hold_left = 0;
      held_once = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            tracker.check_point(rsp_tdata, rsp_tuser, rsp_tlast);
            results_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held_once && results_seen >= 40) begin
            held_once = 1;
            hold_left = STALL_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic send_item(input logic [ACT_W-1:0] act, input logic [PC_W-1:0] pc,
                            input logic [7:0] db, input logic [7:0] xb1,
                            input logic [7:0] xb2, input logic [7:0] yb1,
                            input logic [7:0] yb2);
      calm = (items_sent >= 1300 && items_sent < 1500);
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_DATA_W'({yb2, yb1, xb2, xb1, db, pc});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_item(act, pc, db, xb1, xb2, yb1, yb2);
      case (act)
         ACT_START: n_starts++;
         ACT_FLAG:  n_flags++;
         ACT_STEP:  n_steps++;
         default:   ;
      endcase
      if (act != ACT_UNUSED) items_sent++;
   endtask

   function automatic logic [7:0] rnd_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_start(input logic [PC_W-1:0] pc);
      send_item(ACT_START, pc, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
   endtask

   task automatic send_flag(input logic [7:0] db);
      send_item(ACT_FLAG, PC_W'($urandom_range(0, 2047)), db, rnd_byte(), rnd_byte(),
                rnd_byte(), rnd_byte());
   endtask

   task automatic send_step(input logic [7:0] xb1, input logic [7:0] xb2,
                            input logic [7:0] yb1, input logic [7:0] yb2);
      send_item(ACT_STEP, PC_W'($urandom_range(0, 2047)), rnd_byte(), xb1, xb2, yb1, yb2);
   endtask

   // one glyph: start, flag runs with stray steps and noise, then the points
   task automatic run_glyph(input int unsigned pc, input bit full);
      int unsigned eff;
      int unsigned flags_goal;
      int unsigned planned;
      int unsigned steps_goal;
      int unsigned steps_done;
      int unsigned count;
      logic [7:0]  fb;
      bit          broken;
      eff        = (pc > MAX_POINTS) ? MAX_POINTS : pc;
      broken     = ($urandom_range(0, 99) < 20);
      flags_goal = broken ? $urandom_range(0, eff) : eff + $urandom_range(0, 3);
      steps_goal = eff + (broken ? 1 : $urandom_range(0, 2));
      if (!full && steps_goal > 30) steps_goal = 30;
      planned    = 0;
      steps_done = 0;
      send_start(PC_W'(pc));
      while (planned < flags_goal) begin
         if ($urandom_range(0, 99) < 8) begin
            send_step(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
            steps_done++;
         end else if ($urandom_range(0, 99) < 3) begin
            send_item(ACT_UNUSED, PC_W'($urandom_range(0, 2047)), rnd_byte(), rnd_byte(),
                      rnd_byte(), rnd_byte(), rnd_byte());
         end
         fb = rnd_byte();
         fb[FB_REPEAT] = ($urandom_range(0, 99) < 20);
         send_flag(fb);
         planned++;
         if (fb[FB_REPEAT]) begin
            if (eff > 200)
               count = $urandom_range(100, 255);
            else if ($urandom_range(0, 99) < 85)
               count = $urandom_range(0, 6);
            else
               count = $urandom_range(0, 255);
            send_flag(8'(count));
            planned += count;
         end
      end
      while (steps_done < steps_goal) begin
         send_step(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
         steps_done++;
      end
   endtask

   // stimulus and end of run
   initial begin
      int unsigned pc;
      int unsigned r;
      bit          first;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // step with no glyph started, then an empty glyph
      send_step(8'hFF, 8'hFF, 8'h80, 8'h00);
      send_start(11'd0);
      send_step(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());

      // five points: step before any flag, every axis form, runs past the count
      send_start(11'd5);
      send_step(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
      send_flag(8'h00);      // both axes int16
      send_flag(8'h36);      // both short, positive
      send_flag(8'h06);      // both short, negative
      send_flag(8'h38);      // both same, with repeat
      send_flag(8'd5);       // run overruns the point count
      send_flag(8'hC1);      // beyond the count, dropped
      send_flag(8'h08);      // dropped repeat flag
      send_flag(8'h02);      // its count, dropped too
      send_step(8'h80, 8'h00, 8'h7F, 8'hFF);
      send_step(8'hFF, 8'h00, 8'hFF, 8'h00);
      send_step(8'hFF, 8'h01, 8'h80, 8'h7F);
      send_step(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_step(8'h00, 8'h00, 8'h00, 8'h00);
      send_step(8'h12, 8'h34, 8'h56, 8'h78);

      // unknown action is ignored
      send_item(ACT_UNUSED, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

      // point count above capacity, longest repeat run, zero-length run
      send_start(11'h7FF);
      send_flag(8'hFF);
      send_flag(8'hFF);
      send_step(8'hFF, 8'h00, 8'h01, 8'h00);
      send_step(8'h7F, 8'hFF, 8'h80, 8'h01);
      send_flag(8'h0A);
      send_flag(8'h00);
      send_step(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());

      // random glyphs, the first one at full capacity and stepped to the end
      first = 1;
      while (items_sent < 1725) begin
         if (first) begin
            pc = $urandom_range(1024, 2047);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 85)
               pc = $urandom_range(1, 16);
            else if (r < 95)
               pc = $urandom_range(17, 200);
            else
               pc = $urandom_range(0, 2047);
         end
         run_glyph(pc, first);
         first = 0;
      end
      req_tvalid <= 1'b0;

      // drain, then let any repeat run finish
      while (tracker.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("sent %0d items: %0d glyph starts, %0d flag bytes, %0d point steps",
               items_sent, n_starts, n_flags, n_steps);
      $display("checked %0d results: %0d points, %0d flags short, %0d past the end",
               results_seen, tracker.n_ok, tracker.n_short, tracker.n_done);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("[glyph_point_decoder] OK");
      end else begin
         $display("[glyph_point_decoder] ERROR");
      end
      $finish;
   end

endmodule
